@@ rtl/bfha_pkg.sv @@
// bfha_pkg: shared codes and types for the best-fit heap allocator
// no dependencies; imported by best_fit_heap_allocator
package bfha_pkg;

    typedef logic [1:0] t_status;

    localparam logic    FREE       = 1'b0;
    localparam logic    ALLOCED    = 1'b1;

    localparam logic    OP_ALLOC   = 1'b0;
    localparam logic    OP_FREE    = 1'b1;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOFIT   = 2'd1;
    localparam t_status ST_BADFREE = 2'd2;

endpackage

@@ rtl/best_fit_heap_allocator.sv @@
// best_fit_heap_allocator: best-fit allocator over an implicit header chain
// depends on bfha_pkg; header store is a one-port-read, one-port-write memory
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_opcode, i_request_size,
//          |           |                        | i_block_address
//  out     | output    | o_out_valid / i_out_stall| o_payload_address, o_status
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_heap_size
//
// each transaction walks the header chain one block at a time (memory read in S_RD,
// then evaluate in S_EV); after the walk a no fit goes to S_DONE, an exact fit through
// S_WR, a split through S_SPLIT and S_WR, and a free through S_NRD, S_NEV and S_WR.
// a free below the header size goes straight to S_DONE. after reset and after each
// heap_size write the S_INIT state rewrites the header at offset 0. a result waits in the
// output register while the next request is taken; the walk stalls at its end until
// that register frees.
module best_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_opcode,
    input  logic [11:0]          i_request_size,
    input  logic [11:0]          i_block_address,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [11:0]          o_payload_address,
    output bfha_pkg::t_status    o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [12:0]          i_heap_size
);
    import bfha_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int OW = AW + 1;
    localparam int NW = OW + 1;
    localparam int RW = ((AW > 12) ? AW : 12) + 1;
    localparam int DW = AW + 1;
    localparam int XW = (OW > 13) ? OW : 13;
    localparam int PW = (OW > 12) ? OW : 12;
    localparam logic [OW-1:0] HIU_RST = (4096 > HEAP_BYTES) ? OW'(HEAP_BYTES) : OW'(4096);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD, S_EV, S_NRD, S_NEV, S_SPLIT, S_WR, S_DONE
    } t_state;

    t_state          r_state;
    logic [OW-1:0]   r_hiu;
    logic            r_op;
    logic [11:0]     r_req;
    logic [11:0]     r_target;
    logic [AW-1:0]   r_off;
    logic            r_found;
    logic [AW-1:0]   r_best;
    logic [AW-1:0]   r_best_left;
    logic            r_has_prev;
    logic            r_prev_free;
    logic [AW-1:0]   r_prev_off;
    logic [AW-1:0]   r_prev_size;
    logic [AW-1:0]   r_tsize;
    logic [AW-1:0]   r_nxt;
    logic            r_has_nxt;
    logic [AW-1:0]   r_wa;
    logic [DW-1:0]   r_wd;
    logic [11:0]     r_res_addr;
    t_status         r_res_status;
    logic            r_out_valid;
    logic [11:0]     r_out_addr;
    t_status         r_out_status;

    logic [DW-1:0]   r_mem [HEAP_BYTES];
    logic [DW-1:0]   r_rdata;

    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [DW-1:0]   mem_wd;
    logic [AW-1:0]   mem_ra;

    logic            cur_stat;
    logic [AW-1:0]   cur_size;
    logic [NW-1:0]   nxt;
    logic            at_end;
    logic            fits;
    logic [AW-1:0]   left;
    logic            exact;
    logic            better;
    logic            hit;
    logic [XW-1:0]   cfg_x;
    logic [OW-1:0]   cfg_hiu;
    logic [PW-1:0]   pay_sum;
    logic [RW-1:0]   split_sum;
    logic            nf;
    logic [OW-1:0]   merge_sum;
    logic            in_take;
    logic            out_free;

    // input held off while a request is in progress and while a heap_size write re-creates the heap
    assign o_in_stall        = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_payload_address = r_out_addr;
    assign o_status          = r_out_status;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // current header and chain step
    assign cur_stat  = r_rdata[0];
    assign cur_size  = r_rdata[DW-1:1];
    assign nxt       = NW'(r_off) + NW'(HEADER_BYTES) + NW'(cur_size);
    assign at_end    = (nxt >= NW'(r_hiu));
    assign fits      = (cur_stat == FREE) && (RW'(cur_size) >= RW'(r_req));
    assign left      = cur_size - AW'(r_req);
    assign exact     = fits && (left == '0);
    assign better    = fits && (left >= AW'(HEADER_BYTES)) &&
                       (!r_found || (left < r_best_left));
    assign hit       = (RW'(r_off) == RW'(r_target));
    assign pay_sum   = PW'(r_best) + PW'(HEADER_BYTES);
    assign split_sum = RW'(r_best) + RW'(HEADER_BYTES) + RW'(r_req);
    assign nf        = r_has_nxt && (cur_stat == FREE);

    always_comb begin
        cfg_x = XW'(i_heap_size);
        if (cfg_x < XW'(HEADER_BYTES)) begin
            cfg_hiu = OW'(HEADER_BYTES);
        end else if (cfg_x > XW'(HEAP_BYTES)) begin
            cfg_hiu = OW'(HEAP_BYTES);
        end else begin
            cfg_hiu = OW'(cfg_x);
        end
    end

    // merged size of a freed block with its free neighbors
    always_comb begin
        if (r_has_prev && r_prev_free) begin
            merge_sum = OW'(r_prev_size) + OW'(r_tsize) + OW'(HEADER_BYTES);
            if (nf) begin
                merge_sum = merge_sum + OW'(cur_size) + OW'(HEADER_BYTES);
            end
        end else if (nf) begin
            merge_sum = OW'(r_tsize) + OW'(cur_size) + OW'(HEADER_BYTES);
        end else begin
            merge_sum = OW'(r_tsize);
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wa;
        mem_wd = r_wd;
        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wa = '0;
                mem_wd = {AW'(r_hiu - OW'(HEADER_BYTES)), FREE};
            end
            S_SPLIT: begin
                mem_we = 1'b1;
                mem_wa = split_sum[AW-1:0];
                mem_wd = {r_best_left - AW'(HEADER_BYTES), FREE};
            end
            S_WR: begin
                mem_we = 1'b1;
                if (r_op == OP_ALLOC) begin
                    mem_wa = r_best;
                    mem_wd = {AW'(r_req), ALLOCED};
                end
            end
            default: mem_we = 1'b0;
        endcase
    end

    assign mem_ra = (r_state == S_NRD) ? r_nxt : r_off;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_hiu       <= HIU_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free && !i_cfg_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // heap re-creation on a register write
            if (i_cfg_valid) begin
                r_hiu   <= cfg_hiu;
                r_state <= S_INIT;
            end else begin
                case (r_state)
                    S_INIT: r_state <= S_IDLE;
                    S_IDLE: begin
                        if (in_take) begin
                            r_op        <= i_opcode;
                            r_req       <= i_request_size;
                            r_target    <= i_block_address - 12'(HEADER_BYTES);
                            r_off       <= '0;
                            r_found     <= 1'b0;
                            r_best_left <= '0;
                            r_has_prev  <= 1'b0;
                            if (i_opcode == OP_FREE &&
                                i_block_address < 12'(HEADER_BYTES)) begin
                                r_res_addr   <= '0;
                                r_res_status <= ST_BADFREE;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                    end
                    S_RD: r_state <= S_EV;
                    S_EV: begin
                        if (r_op == OP_ALLOC) begin
                            if (exact) begin
                                r_best      <= r_off;
                                r_best_left <= '0;
                                r_state     <= S_WR;
                            end else begin
                                if (better) begin
                                    r_best      <= r_off;
                                    r_best_left <= left;
                                    r_found     <= 1'b1;
                                end
                                if (at_end) begin
                                    if (r_found || better) begin
                                        r_state <= S_SPLIT;
                                    end else begin
                                        r_res_addr   <= '0;
                                        r_res_status <= ST_NOFIT;
                                        r_state      <= S_DONE;
                                    end
                                end else begin
                                    r_off   <= nxt[AW-1:0];
                                    r_state <= S_RD;
                                end
                            end
                        end else if (hit) begin
                            if (cur_stat == FREE) begin
                                r_res_addr   <= '0;
                                r_res_status <= ST_BADFREE;
                                r_state      <= S_DONE;
                            end else begin
                                r_tsize   <= cur_size;
                                r_nxt     <= nxt[AW-1:0];
                                r_has_nxt <= !at_end;
                                r_state   <= S_NRD;
                            end
                        end else begin
                            r_prev_off  <= r_off;
                            r_prev_free <= (cur_stat == FREE);
                            r_prev_size <= cur_size;
                            r_has_prev  <= 1'b1;
                            if (at_end) begin
                                r_res_addr   <= '0;
                                r_res_status <= ST_BADFREE;
                                r_state      <= S_DONE;
                            end else begin
                                r_off   <= nxt[AW-1:0];
                                r_state <= S_RD;
                            end
                        end
                    end
                    S_NRD: r_state <= S_NEV;
                    S_NEV: begin
                        r_wa    <= (r_has_prev && r_prev_free) ? r_prev_off : r_off;
                        r_wd    <= {merge_sum[AW-1:0], FREE};
                        r_state <= S_WR;
                    end
                    S_SPLIT: r_state <= S_WR;
                    S_WR: begin
                        r_res_addr   <= (r_op == OP_ALLOC) ? pay_sum[11:0] : 12'd0;
                        r_res_status <= ST_OK;
                        r_state      <= S_DONE;
                    end
                    S_DONE: begin
                        if (out_free) begin
                            r_out_addr   <= r_res_addr;
                            r_out_status <= r_res_status;
                            r_state      <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

endmodule
